// ----- hdl/lrc_pkg.sv -----
package lrc_pkg;

    // Field widths.
    localparam int SAMPLE_BITS   = 12;
    localparam int FRACTION_BITS = 12;
    localparam int VALUE_BITS    = 16;
    localparam int PHASE_BITS    = 3;
    localparam int CFG_BITS      = 2;

    // The divider works on the magnitude of (sample - min) scaled up by the fraction bits.
    localparam int DIVIDEND_BITS = SAMPLE_BITS + FRACTION_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS);

    // Calibration phases, as reported on the phase field.
    localparam logic [PHASE_BITS-1:0] PH_WAIT_REST    = 3'd0;
    localparam logic [PHASE_BITS-1:0] PH_WAIT_FULL    = 3'd1;
    localparam logic [PHASE_BITS-1:0] PH_WAIT_RETURN  = 3'd2;
    localparam logic [PHASE_BITS-1:0] PH_WAIT_FULL2   = 3'd3;
    localparam logic [PHASE_BITS-1:0] PH_WAIT_RETURN2 = 3'd4;
    localparam logic [PHASE_BITS-1:0] PH_DONE         = 3'd5;

    // Reset value of the cycle count register.
    localparam logic [CFG_BITS-1:0] CYCLES_RESET = 2'd1;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] lever_sample;
        logic                   rest_switch_open;
        logic                   full_switch_open;
    } in_item_t;

    typedef struct packed {
        logic [PHASE_BITS-1:0]        phase;
        logic signed [VALUE_BITS-1:0] lever_value;
        logic                         range_zero;
        logic [SAMPLE_BITS-1:0]       low_reading;
        logic [SAMPLE_BITS-1:0]       high_reading;
    } out_item_t;

    // Handshake between the sequencer and the divider.
    typedef struct packed {
        logic done;
    } div_status_t;

endpackage

// ----- hdl/lrc_div.sv -----
module lrc_div (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [lrc_pkg::DIVIDEND_BITS-1:0]    dividend,
    input  logic [lrc_pkg::SAMPLE_BITS-1:0]      divisor,
    output logic [lrc_pkg::DIVIDEND_BITS-1:0]    quotient,
    output lrc_pkg::div_status_t                 status
);

    logic [lrc_pkg::SAMPLE_BITS-1:0]   rem_reg;
    logic [lrc_pkg::SAMPLE_BITS-1:0]   rem_next;
    logic [lrc_pkg::DIVIDEND_BITS-1:0] quo_reg;
    logic [lrc_pkg::DIVIDEND_BITS-1:0] quo_next;
    logic [lrc_pkg::SAMPLE_BITS-1:0]   den_reg;
    logic [lrc_pkg::DIV_CNT_BITS-1:0]  cnt_reg;
    logic                              busy_reg;
    logic                              done_reg;
    logic [lrc_pkg::SAMPLE_BITS:0]     shifted;
    logic [lrc_pkg::SAMPLE_BITS:0]     trial;

    // One restoring step: shift in the next dividend bit and try to subtract the divisor.
    always_comb begin
        shifted = {rem_reg, quo_reg[lrc_pkg::DIVIDEND_BITS-1]};
        trial   = shifted - {1'b0, den_reg};
        if (!trial[lrc_pkg::SAMPLE_BITS]) begin
            rem_next = trial[lrc_pkg::SAMPLE_BITS-1:0];
            quo_next = {quo_reg[lrc_pkg::DIVIDEND_BITS-2:0], 1'b1};
        end else begin
            rem_next = shifted[lrc_pkg::SAMPLE_BITS-1:0];
            quo_next = {quo_reg[lrc_pkg::DIVIDEND_BITS-2:0], 1'b0};
        end
    end

    // Control: one quotient bit per cycle, a done pulse after the last one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == lrc_pkg::DIV_CNT_BITS'(lrc_pkg::DIVIDEND_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient    = quo_reg;
    assign status.done = done_reg;

endmodule

// ----- hdl/lever_range_calibrator.sv -----
// Lever range calibrator.
// Items arrive on the s_ channel (valid/ready) and each gives exactly one
// result item on the m_ channel (valid/ready). The block tracks the minimum
// and maximum lever sample while it walks through the rest/full/rest phases,
// and once calibrated it reports the normalised position in Q3.12.
// cfg_wr_en/cfg_wr_data set the number of lever cycles needed (1 or 2); the
// user must write it only while the block is idle, which the block does not enforce.
// An item is taken only in the idle state. An item that leaves the block
// uncalibrated, or finds a zero range, goes from the prepare state straight
// to the emit state. A calibrated item first goes through a restoring divider
// that yields one quotient bit per cycle over 24 bits, then to the emit state.
// A finished result sits in the output register while the receiver stalls;
// the next item then waits in the emit state and no further item is taken.
// Reset clears the phase to waiting for rest, clears the tracked minimum and
// maximum, sets the cycle count to one and leaves the output empty.
module lever_range_calibrator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [lrc_pkg::CFG_BITS-1:0]   cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  lrc_pkg::in_item_t              s_item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output lrc_pkg::out_item_t             m_item
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam int VALUE_MAG = 1 << (lrc_pkg::VALUE_BITS - 1);
    localparam logic [lrc_pkg::VALUE_BITS-1:0] VALUE_MAX = lrc_pkg::VALUE_BITS'(VALUE_MAG - 1);
    localparam logic [lrc_pkg::VALUE_BITS-1:0] VALUE_MIN = lrc_pkg::VALUE_BITS'(VALUE_MAG);

    logic [1:0]                          state_reg;
    logic [1:0]                          state_next;
    logic [lrc_pkg::PHASE_BITS-1:0]      phase_reg;
    logic [lrc_pkg::PHASE_BITS-1:0]      phase_next;
    logic [lrc_pkg::SAMPLE_BITS-1:0]     min_reg;
    logic [lrc_pkg::SAMPLE_BITS-1:0]     min_next;
    logic [lrc_pkg::SAMPLE_BITS-1:0]     max_reg;
    logic [lrc_pkg::SAMPLE_BITS-1:0]     max_next;
    logic [lrc_pkg::CFG_BITS-1:0]        cycles_reg;
    logic [lrc_pkg::SAMPLE_BITS-1:0]     sample_reg;
    logic                                neg_reg;
    logic [lrc_pkg::VALUE_BITS-1:0]      value_reg;
    logic [lrc_pkg::VALUE_BITS-1:0]      value_next;
    logic                                zero_reg;
    logic                                m_valid_reg;
    lrc_pkg::out_item_t                  m_item_reg;

    logic                                accept;
    logic                                at_rest;
    logic                                at_full;
    logic [lrc_pkg::SAMPLE_BITS:0]       diff;
    logic [lrc_pkg::SAMPLE_BITS-1:0]     diff_mag;
    logic [lrc_pkg::SAMPLE_BITS-1:0]     range;
    logic                                div_start;
    logic [lrc_pkg::DIVIDEND_BITS-1:0]   quotient;
    lrc_pkg::div_status_t                div_status;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign at_rest = !s_item.rest_switch_open;
    assign at_full = !s_item.full_switch_open;

    // Range tracking and the calibration phase machine, applied to the accepted item.
    always_comb begin
        min_next   = min_reg;
        max_next   = max_reg;
        phase_next = phase_reg;
        if (phase_reg != lrc_pkg::PH_DONE) begin
            if (s_item.lever_sample < min_reg) begin
                min_next = s_item.lever_sample;
            end
            if (s_item.lever_sample > max_reg) begin
                max_next = s_item.lever_sample;
            end
            unique case (phase_reg)
                lrc_pkg::PH_WAIT_REST: begin
                    if (at_rest) begin
                        min_next   = s_item.lever_sample;
                        max_next   = s_item.lever_sample;
                        phase_next = lrc_pkg::PH_WAIT_FULL;
                    end
                end
                lrc_pkg::PH_WAIT_FULL: begin
                    if (at_full) begin
                        phase_next = lrc_pkg::PH_WAIT_RETURN;
                    end
                end
                lrc_pkg::PH_WAIT_RETURN: begin
                    if (at_rest) begin
                        phase_next = cycles_reg[1] ? lrc_pkg::PH_WAIT_FULL2
                                                   : lrc_pkg::PH_DONE;
                    end
                end
                lrc_pkg::PH_WAIT_FULL2: begin
                    if (at_full) begin
                        phase_next = lrc_pkg::PH_WAIT_RETURN2;
                    end
                end
                lrc_pkg::PH_WAIT_RETURN2: begin
                    if (at_rest) begin
                        phase_next = lrc_pkg::PH_DONE;
                    end
                end
                default: begin
                    phase_next = lrc_pkg::PH_WAIT_REST;
                end
            endcase
        end
    end

    // Offset of the sample from the minimum, and the calibrated range.
    always_comb begin
        diff     = {1'b0, sample_reg} - {1'b0, min_reg};
        diff_mag = diff[lrc_pkg::SAMPLE_BITS] ? lrc_pkg::SAMPLE_BITS'(-diff)
                                               : diff[lrc_pkg::SAMPLE_BITS-1:0];
        range    = max_reg - min_reg;
    end

    assign div_start = (state_reg == ST_PREP) && (phase_reg == lrc_pkg::PH_DONE)
                       && (range != '0);

    lrc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({diff_mag, {lrc_pkg::FRACTION_BITS{1'b0}}}),
        .divisor  (range),
        .quotient (quotient),
        .status   (div_status)
    );

    // Saturate the quotient magnitude and apply the sign.
    always_comb begin
        if (!neg_reg) begin
            if (quotient > lrc_pkg::DIVIDEND_BITS'(VALUE_MAG - 1)) begin
                value_next = VALUE_MAX;
            end else begin
                value_next = quotient[lrc_pkg::VALUE_BITS-1:0];
            end
        end else begin
            if (quotient > lrc_pkg::DIVIDEND_BITS'(VALUE_MAG)) begin
                value_next = VALUE_MIN;
            end else begin
                value_next = lrc_pkg::VALUE_BITS'(-quotient[lrc_pkg::VALUE_BITS-1:0]);
            end
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                state_next = div_start ? ST_DIV : ST_EMIT;
            end
            ST_DIV: begin
                if (div_status.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= lrc_pkg::PH_WAIT_REST;
            min_reg     <= '0;
            max_reg     <= '0;
            cycles_reg  <= lrc_pkg::CYCLES_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                cycles_reg <= cfg_wr_data;
            end
            if (accept) begin
                phase_reg <= phase_next;
                min_reg   <= min_next;
                max_reg   <= max_next;
            end
            if (state_reg == ST_EMIT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Item payload and result registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_item.lever_sample;
        end
        if (state_reg == ST_PREP) begin
            neg_reg   <= diff[lrc_pkg::SAMPLE_BITS];
            value_reg <= '0;
            zero_reg  <= (phase_reg == lrc_pkg::PH_DONE) && (range == '0);
        end
        if (state_reg == ST_DIV && div_status.done) begin
            value_reg <= value_next;
        end
        if (state_reg == ST_EMIT && (!m_valid_reg || m_ready)) begin
            m_item_reg.phase        <= phase_reg;
            m_item_reg.lever_value  <= value_reg;
            m_item_reg.range_zero   <= zero_reg;
            m_item_reg.low_reading  <= min_reg;
            m_item_reg.high_reading <= max_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [lrc_pkg::CFG_BITS-1:0]  cfg_wr_data = '0;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    lrc_pkg::in_item_t             s_item      = '0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    lrc_pkg::out_item_t            m_item;

    // Items waiting to be offered, and results still owed by the block.
    lrc_pkg::in_item_t  pending_levers[$];
    lrc_pkg::out_item_t owed_results[$];
    int                 mismatches = 0;

    // Own copy of the calibration state and the cycle count register.
    logic [lrc_pkg::PHASE_BITS-1:0]  cal_phase_m = lrc_pkg::PH_WAIT_REST;
    logic [lrc_pkg::SAMPLE_BITS-1:0] low_m       = '0;
    logic [lrc_pkg::SAMPLE_BITS-1:0] high_m      = '0;
    logic [lrc_pkg::CFG_BITS-1:0]    cycles_m    = lrc_pkg::CYCLES_RESET;

    // Sender burst shaping and receiver stall pattern.
    int        burst_left  = 1;
    int        gap_left    = 0;
    logic [7:0] stall_pattern = 8'hFF;
    int        pattern_age = 0;

    lever_range_calibrator u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

    always #10 aclk = ~aclk;

    // Advance the calibration state by one lever item and return the result it gives.
    function automatic lrc_pkg::out_item_t calibrate_step(input lrc_pkg::in_item_t it);
        lrc_pkg::out_item_t              res;
        logic [lrc_pkg::SAMPLE_BITS-1:0] s;
        logic                            at_rest;
        logic                            at_full;
        longint                          num;
        longint                          den;
        longint                          quo;
        s       = it.lever_sample;
        at_rest = !it.rest_switch_open;
        at_full = !it.full_switch_open;
        if (cal_phase_m != lrc_pkg::PH_DONE) begin
            if (s < low_m) low_m = s;
            if (s > high_m) high_m = s;
            case (cal_phase_m)
                lrc_pkg::PH_WAIT_REST: begin
                    if (at_rest) begin
                        low_m       = s;
                        high_m      = s;
                        cal_phase_m = lrc_pkg::PH_WAIT_FULL;
                    end
                end
                lrc_pkg::PH_WAIT_FULL: begin
                    if (at_full) cal_phase_m = lrc_pkg::PH_WAIT_RETURN;
                end
                lrc_pkg::PH_WAIT_RETURN: begin
                    if (at_rest) cal_phase_m = (cycles_m >= 2) ? lrc_pkg::PH_WAIT_FULL2
                                                                : lrc_pkg::PH_DONE;
                end
                lrc_pkg::PH_WAIT_FULL2: begin
                    if (at_full) cal_phase_m = lrc_pkg::PH_WAIT_RETURN2;
                end
                lrc_pkg::PH_WAIT_RETURN2: begin
                    if (at_rest) cal_phase_m = lrc_pkg::PH_DONE;
                end
                default: begin
                    cal_phase_m = lrc_pkg::PH_WAIT_REST;
                end
            endcase
        end
        res              = '0;
        res.phase        = cal_phase_m;
        res.low_reading  = low_m;
        res.high_reading = high_m;
        if (cal_phase_m == lrc_pkg::PH_DONE) begin
            num = (longint'(s) - longint'(low_m)) * (longint'(1) << lrc_pkg::FRACTION_BITS);
            den = longint'(high_m) - longint'(low_m);
            if (den == 0) begin
                res.range_zero = 1'b1;
            end else begin
                // Signed division truncates toward zero, then clamp to 16 bits.
                quo = num / den;
                if (quo > 32767) quo = 32767;
                if (quo < -32768) quo = -32768;
                res.lever_value = quo[lrc_pkg::VALUE_BITS-1:0];
            end
        end
        return res;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Sender: offers queued items in bursts, and predicts each item as it is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                owed_results.push_back(calibrate_step(s_item));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_levers.size() > 0) begin
                    s_item  <= pending_levers.pop_front();
                    s_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        if ($urandom_range(0, 4) == 0) begin
                            burst_left = $urandom_range(30, 60);
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 8);
                            gap_left   = $urandom_range(0, 40);
                        end
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result against the oldest owed one and stalls on a pattern.
    always @(posedge aclk) begin : result_monitor
        lrc_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_results.size() == 0) begin
                $display("%0t: result with none owed, expected nothing, actual %h", $time,
                         m_item);
                mismatches++;
            end else begin
                want = owed_results.pop_front();
                check_field("phase", longint'(want.phase), longint'(m_item.phase));
                check_field("lever_value", longint'(want.lever_value),
                            longint'(m_item.lever_value));
                check_field("range_zero", longint'(want.range_zero),
                            longint'(m_item.range_zero));
                check_field("low_reading", longint'(want.low_reading),
                            longint'(m_item.low_reading));
                check_field("high_reading", longint'(want.high_reading),
                            longint'(m_item.high_reading));
            end
        end
        m_ready <= stall_pattern[0];
        if (pattern_age >= 63) begin
            pattern_age   = 0;
            stall_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
        end else begin
            pattern_age++;
            stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
        end
    end

    task automatic queue_lever(input logic [lrc_pkg::SAMPLE_BITS-1:0] s,
                               input logic rest_open, input logic full_open);
        lrc_pkg::in_item_t it;
        it.lever_sample     = s;
        it.rest_switch_open = rest_open;
        it.full_switch_open = full_open;
        pending_levers.push_back(it);
    endtask

    // Wait until every queued item is taken and every owed result has arrived, or a wait limit runs out.
    task automatic settle_block();
        int waited;
        waited = 0;
        do @(negedge aclk); while (pending_levers.size() != 0 || s_valid);
        while (owed_results.size() != 0 && waited < 5000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (30) @(negedge aclk);
    endtask

    task automatic write_cycles(input logic [lrc_pkg::CFG_BITS-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        cycles_m     = value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Stimulus: one calibration walk, post-calibration extremes, then random items.
    initial begin
        logic [lrc_pkg::SAMPLE_BITS-1:0] mid;
        logic [lrc_pkg::SAMPLE_BITS-1:0] lo_t;
        logic [lrc_pkg::SAMPLE_BITS-1:0] hi_t;
        logic [lrc_pkg::SAMPLE_BITS-1:0] s;
        int                              span;
        bit                              flat;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // A flat calibration now and then gives the zero range case.
        flat = ($urandom_range(0, 5) == 0);
        mid  = lrc_pkg::SAMPLE_BITS'($urandom_range(1000, 3000));
        span = ($urandom_range(0, 3) == 0) ? int'($urandom_range(201, 900))
                                           : int'($urandom_range(1, 200));
        lo_t = flat ? mid : lrc_pkg::SAMPLE_BITS'(int'(mid) - span / 2);
        hi_t = flat ? mid : lrc_pkg::SAMPLE_BITS'(int'(lo_t) + span);

        write_cycles(2'd3);
        // Before rest the tracked range drifts, then rest snaps both ends to the sample.
        queue_lever(12'd0, 1'b1, 1'b1);
        queue_lever(12'hFFF, 1'b1, 1'b0);
        queue_lever(lrc_pkg::SAMPLE_BITS'($urandom_range(0, 4095)), 1'b1, 1'b1);
        queue_lever(mid, 1'b0, 1'b1);
        queue_lever(lo_t, 1'b1, 1'b1);
        queue_lever(hi_t, 1'b1, 1'b1);
        queue_lever(hi_t, 1'b1, 1'b0);
        queue_lever(mid, 1'b1, 1'b1);
        settle_block();

        // The count in force at the first return decides whether a second rest/full/rest walk is needed.
        write_cycles(lrc_pkg::CFG_BITS'($urandom_range(0, 3)));
        queue_lever(lo_t, 1'b0, 1'b0);
        queue_lever(mid, 1'b1, 1'b0);
        queue_lever(mid, 1'b0, 1'b1);
        settle_block();

        // Calibrated: the ends of the sample range and just outside the tracked range.
        write_cycles(2'd0);
        queue_lever(12'd0, 1'b0, 1'b0);
        queue_lever(12'hFFF, 1'b1, 1'b1);
        queue_lever(lo_t, 1'b1, 1'b0);
        queue_lever(hi_t, 1'b0, 1'b1);
        queue_lever(lo_t - 12'd1, 1'b1, 1'b1);
        queue_lever(hi_t + 12'd1, 1'b0, 1'b1);
        queue_lever(mid, 1'b1, 1'b0);
        settle_block();

        write_cycles(2'd2);
        for (int i = 0; i < 550; i++) begin
            case ($urandom_range(0, 7))
                0:       s = 12'd0;
                1:       s = 12'hFFF;
                2:       s = lrc_pkg::SAMPLE_BITS'(lo_t + $urandom_range(0, hi_t - lo_t));
                3:       s = lrc_pkg::SAMPLE_BITS'(lo_t - $urandom_range(0, 4));
                4:       s = lrc_pkg::SAMPLE_BITS'(hi_t + $urandom_range(0, 4));
                default: s = lrc_pkg::SAMPLE_BITS'($urandom_range(0, 4095));
            endcase
            queue_lever(s, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        settle_block();

        if (owed_results.size() != 0) begin
            $display("%0t: results missing, expected %0d more, actual 0", $time,
                     owed_results.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #20000000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
